@@ hw/rtl/sml_pkg.sv @@
package sml_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = 32;
  localparam int AMT_W    = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LINK_W   = $clog2(CAPACITY + 1);

  localparam logic [LINK_W-1:0] NIL     = LINK_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CNT_MAX = '1;

  localparam logic [1:0] ACT_ADD        = 2'd0;
  localparam logic [1:0] ACT_REMOVE_ONE = 2'd1;
  localparam logic [1:0] ACT_REMOVE_N   = 2'd2;
  localparam logic [1:0] ACT_QUERY      = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;
  localparam logic [1:0] ST_BAD_AMOUNT = 2'd3;

  // one list node as stored in the node RAM
  typedef struct packed {
    logic [LINK_W-1:0]       link;
    logic [CNT_W-1:0]        count;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // result of one item, status in the low bits
  typedef struct packed {
    logic             empty_res;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] count;
    logic [1:0]       status;
  } res_t;

  localparam int RES_W  = $bits(res_t);
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;

endpackage

@@ hw/rtl/sml_ram.sv @@
module sml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/sml_ctrl.sv @@
module sml_ctrl import sml_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_action,
  input  logic signed [KEY_W-1:0] in_key,
  input  logic [AMT_W-1:0]        in_amount,
  output logic                    res_valid,
  input  logic                    res_ready,
  output res_t                    res,
  output logic [ADDR_W-1:0]       rd_addr,
  input  entry_t                  rd_data,
  output logic                    wr_en,
  output logic [ADDR_W-1:0]       wr_addr,
  output entry_t                  wr_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK     = 3'd1;
  localparam logic [2:0] S_DECIDE   = 3'd2;
  localparam logic [2:0] S_ALLOC    = 3'd3;
  localparam logic [2:0] S_INSERT   = 3'd4;
  localparam logic [2:0] S_LINKPREV = 3'd5;
  localparam logic [2:0] S_FREECUR  = 3'd6;
  localparam logic [2:0] S_FIN      = 3'd7;

  logic [2:0]              state;
  logic [1:0]              act;
  logic signed [KEY_W-1:0] key;
  logic [AMT_W-1:0]        amount;
  logic [LINK_W-1:0]       prev;
  logic [LINK_W-1:0]       cur;
  entry_t                  prev_ent;
  entry_t                  cur_ent;
  logic [ADDR_W-1:0]       steps;
  logic                    found;
  logic [LINK_W-1:0]       first_node;
  logic [LINK_W-1:0]       free_head;
  logic [LINK_W-1:0]       fresh;
  logic [ADDR_W-1:0]       new_node;
  logic [CNT_W-1:0]        total;
  logic [1:0]              res_status;
  logic [CNT_W-1:0]        res_count;

  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  total_inc;
  logic [CNT_W-1:0]  rm_amt;
  logic              rm_keep;
  logic [CNT_W-1:0]  rm_cnt;
  logic [CNT_W-1:0]  total_dec;
  logic [LINK_W-1:0] prev_link;

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  assign res.status    = res_status;
  assign res.count     = res_count;
  assign res.total     = total;
  assign res.empty_res = (first_node == NIL);

  assign cnt_inc   = (cur_ent.count == CNT_MAX) ? cur_ent.count : cur_ent.count + 1'b1;
  assign total_inc = (total == CNT_MAX) ? total : total + 1'b1;
  assign rm_amt    = (act == ACT_REMOVE_ONE) ? CNT_W'(1) : CNT_W'(amount);
  assign rm_keep   = (cur_ent.count > rm_amt);
  assign rm_cnt    = rm_keep ? rm_amt : cur_ent.count;
  assign total_dec = (total > rm_cnt) ? total - rm_cnt : '0;
  // predecessor either gains the new node or skips the freed one
  assign prev_link = (act == ACT_ADD) ? LINK_W'(new_node) : cur_ent.link;

  // chase the link straight out of the read register: one node per cycle
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = first_node[ADDR_W-1:0];
      S_WALK:   rd_addr = rd_data.link[ADDR_W-1:0];
      S_DECIDE: rd_addr = free_head[ADDR_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur[ADDR_W-1:0];
    wr_data = cur_ent;
    unique case (state)
      S_DECIDE: begin
        if (found) begin
          case (act) inside
            ACT_ADD: begin
              wr_en         = 1'b1;
              wr_data.count = cnt_inc;
            end
            ACT_REMOVE_ONE, ACT_REMOVE_N: begin
              wr_en         = rm_keep;
              wr_data.count = cur_ent.count - rm_amt;
            end
            default: ;
          endcase
        end
      end
      S_INSERT: begin
        wr_en         = 1'b1;
        wr_addr       = new_node;
        wr_data.link  = cur;
        wr_data.count = CNT_W'(1);
        wr_data.key   = key;
      end
      S_LINKPREV: begin
        wr_en        = (prev != NIL);
        wr_addr      = prev[ADDR_W-1:0];
        wr_data      = prev_ent;
        wr_data.link = prev_link;
      end
      S_FREECUR: begin
        wr_en        = 1'b1;
        wr_data.link = free_head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      first_node <= NIL;
      free_head  <= NIL;
      fresh      <= '0;
      total      <= '0;
      found      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act        <= in_action;
            key        <= in_key;
            amount     <= in_amount;
            prev       <= NIL;
            cur        <= first_node;
            steps      <= '0;
            found      <= 1'b0;
            res_status <= ST_OK;
            res_count  <= '0;
            if (in_action == ACT_REMOVE_N && in_amount == '0) begin
              res_status <= ST_BAD_AMOUNT;
              state      <= S_FIN;
            end else if (first_node == NIL) begin
              state <= S_DECIDE;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (rd_data.key == key) begin
            found   <= 1'b1;
            cur_ent <= rd_data;
            state   <= S_DECIDE;
          end else if (rd_data.key > key) begin
            cur_ent <= rd_data;
            state   <= S_DECIDE;
          end else begin
            prev     <= cur;
            prev_ent <= rd_data;
            cur      <= rd_data.link;
            steps    <= steps + 1'b1;
            if (rd_data.link == NIL || steps == ADDR_W'(CAPACITY - 1)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          state <= S_FIN;
          case (act) inside
            ACT_ADD: begin
              if (found) begin
                res_count <= cnt_inc;
                total     <= total_inc;
              end else if (free_head != NIL) begin
                new_node <= free_head[ADDR_W-1:0];
                state    <= S_ALLOC;
              end else if (fresh != NIL) begin
                new_node <= fresh[ADDR_W-1:0];
                fresh    <= fresh + 1'b1;
                state    <= S_INSERT;
              end else begin
                res_status <= ST_FULL;
              end
            end
            ACT_REMOVE_ONE, ACT_REMOVE_N: begin
              if (!found) begin
                res_status <= ST_NOT_FOUND;
              end else begin
                res_count <= rm_cnt;
                total     <= total_dec;
                if (!rm_keep) begin
                  state <= S_LINKPREV;
                end
              end
            end
            default: begin
              if (found) begin
                res_count <= cur_ent.count;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
          endcase
        end
        S_ALLOC: begin
          // pop the free list: the freed node holds the next free link
          free_head <= rd_data.link;
          state     <= S_INSERT;
        end
        S_INSERT: begin
          res_count <= CNT_W'(1);
          total     <= total_inc;
          state     <= S_LINKPREV;
        end
        S_LINKPREV: begin
          if (prev == NIL) begin
            first_node <= prev_link;
          end
          state <= (act == ACT_ADD) ? S_FIN : S_FREECUR;
        end
        S_FREECUR: begin
          free_head <= cur;
          state     <= S_FIN;
        end
        S_FIN: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/sorted_multiset_list.sv @@
// Sorted multiset of signed 32-bit keys held as an ascending linked list in a
// 64-node RAM. Each item (add one, remove one, remove up to amount, query)
// gives one result item with status, count, running total and an empty flag.
// The block takes one item at a time. To find the key or its place, the block
// walks the list and reads at most 64 nodes: the walk chases links through the
// single read port of the node RAM, one node per cycle, and the update then
// writes back up to two nodes. A remove up to amount with a zero amount is
// answered with a bad amount status and no walk. A finished result waits in
// the output register while the next item is taken. No clearing pass follows
// reset.
module sorted_multiset_list import sml_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [47:0]      s_tdata,   // key[31:0], amount[47:32]
  input  logic [1:0]       s_tuser,   // action[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[1:0], count[33:2], total[65:34], empty_res[66]
);

  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  sml_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sml_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_key    (s_tdata[KEY_W-1:0]),
    .in_amount (s_tdata[KEY_W+AMT_W-1:KEY_W]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= OUT_W'(res);
    end
  end

endmodule

@@ hw/rtl/sml_checker.sv @@
module sml_checker import sml_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [47:0]      s_tdata,
  input logic [1:0]       s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [1:0]       o_status;
  logic [CNT_W-1:0] o_count;
  logic             o_empty;

  assign o_status = m_tdata[1:0];
  assign o_count  = m_tdata[CNT_W+1:2];
  assign o_empty  = m_tdata[2*CNT_W+2];

  // one item in flight: no second accept right after the first
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_fail_no_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status != ST_OK) |-> (o_count == '0))
    else $error("failed action reports a count");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status == ST_FULL) |-> !o_empty)
    else $error("full reported on an empty list");

endmodule

bind sorted_multiset_list sml_checker u_sml_checker (.*);
